### rtl/core/gpfl_pkg.sv
`default_nettype none

package gpfl_pkg;

    localparam int ID_W            = 12;
    localparam int CNT_W           = 13;
    localparam int POOL_DEPTH_DEF  = 4096;
    localparam int GROW_STEP_DEF   = 64;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 13'd4096;
    localparam logic             REG_MAX_ENTRIES = 1'b0;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_BADID = 2'd2
    } alloc_status_t;

    typedef enum logic {
        ACT_ALLOC   = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } fsm_t;

    typedef struct packed {
        action_t           action;
        logic [ID_W-1:0]   release_id;
    } req_t;

    typedef struct packed {
        alloc_status_t     status;
        logic [ID_W-1:0]   granted_id;
        logic [CNT_W-1:0]  free_count;
    } rsp_t;

endpackage

`default_nettype wire

### rtl/core/gpfl_ram.sv
`default_nettype none

module gpfl_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/gpfl_engine.sv
`default_nettype none

module gpfl_engine
    import gpfl_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF,
    parameter int GROW_STEP  = GROW_STEP_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire req_t             req,
    input  wire logic [CNT_W-1:0] max_entries,
    output      logic             busy,
    output      logic             done,
    output      rsp_t             rsp
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int KW = (CW > CNT_W) ? CW : CNT_W;
    localparam logic [KW:0] POOL_K = (KW+1)'(POOL_DEPTH);
    localparam logic [KW:0] STEP_K = (KW+1)'(GROW_STEP);

    fsm_t state_reg, state_next;
    logic accept;
    logic exec_en;

    logic [CW-1:0]   hw_reg, hw_next;
    logic [CW-1:0]   cap_reg, cap_next;
    logic [CW-1:0]   len_reg, len_next;
    logic [ID_W-1:0] head_reg, head_next;
    logic [ID_W-1:0] tail_reg, tail_next;
    logic            done_reg, done_next;
    req_t            req_reg;
    rsp_t            rsp_reg, rsp_next;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    logic [ID_W-1:0] mem_rdata;

    logic [KW:0]     hw_k, cap_k, len_k, rid_k, max_k, grow_sum;
    logic            list_empty, need_grow, grow_ok;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        busy    = 1'b0;
        exec_en = 1'b0;
        case (state_reg)
            S_IDLE:  busy = 1'b0;
            S_EXEC:
            begin
                busy    = 1'b1;
                exec_en = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    assign accept    = start && !busy;
    assign mem_raddr = AW'({{AW{1'b0}}, head_reg});
    assign mem_waddr = AW'({{AW{1'b0}}, tail_reg});

    assign hw_k  = (KW+1)'({{(KW+1){1'b0}}, hw_reg});
    assign cap_k = (KW+1)'({{(KW+1){1'b0}}, cap_reg});
    assign len_k = (KW+1)'({{(KW+1){1'b0}}, len_reg});
    assign rid_k = (KW+1)'({{(KW+1){1'b0}}, req_reg.release_id});
    assign max_k = (KW+1)'({{(KW+1){1'b0}}, max_entries});

    assign list_empty = (len_reg == '0);
    assign need_grow  = list_empty && (hw_k >= cap_k);
    assign grow_ok    = (cap_k < max_k) && (cap_k < POOL_K);
    assign grow_sum   = cap_k + STEP_K;

    always_comb
    begin
        hw_next   = hw_reg;
        cap_next  = cap_reg;
        len_next  = len_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        done_next = 1'b0;
        rsp_next  = rsp_reg;
        mem_we    = 1'b0;
        if (exec_en)
        begin
            done_next           = 1'b1;
            rsp_next.status     = ST_OK;
            rsp_next.granted_id = '0;
            if (req_reg.action == ACT_ALLOC)
            begin
                if (need_grow && !grow_ok)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    if (need_grow)
                    begin
                        cap_next = (grow_sum > POOL_K) ? CW'(POOL_K) : CW'(grow_sum);
                    end
                    if (list_empty)
                    begin
                        rsp_next.granted_id = ID_W'({{ID_W{1'b0}}, hw_reg});
                        hw_next             = hw_reg + 1'b1;
                    end
                    else
                    begin
                        rsp_next.granted_id = head_reg;
                        if (len_reg != CW'(1))
                        begin
                            head_next = mem_rdata;
                        end
                        len_next = len_reg - 1'b1;
                    end
                end
            end
            else
            begin
                if ((rid_k >= hw_k) || (len_k >= hw_k))
                begin
                    rsp_next.status = ST_BADID;
                end
                else
                begin
                    if (list_empty)
                    begin
                        head_next = req_reg.release_id;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                    tail_next = req_reg.release_id;
                    len_next  = len_reg + 1'b1;
                end
            end
            rsp_next.free_count = CNT_W'({{CNT_W{1'b0}}, len_next});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hw_reg    <= '0;
            cap_reg   <= '0;
            len_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hw_reg    <= hw_next;
            cap_reg   <= cap_next;
            len_reg   <= len_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    gpfl_ram #(
        .WIDTH (ID_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req_reg.release_id),
        .re    (accept),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

### rtl/core/growing_pool_free_list_allocator.sv
// channel  | handshake            | word
// ---------+----------------------+---------------------------------------
// request  | start / busy         | req : action, release_id
// result   | done (one cycle)     | rsp : status, granted_id, free_count
// config   | apb psel/penable     | max_entries at byte address 0
//
// each request is a link memory read of the list head, then the update;
// a new request is taken while the previous result shows
// reset clears counters and list pointers; link memory is not cleared
// the result receiver cannot stall; done is high for exactly one cycle
`default_nettype none

module growing_pool_free_list_allocator
    import gpfl_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF,
    parameter int GROW_STEP  = GROW_STEP_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire req_t               req,
    output      logic               busy,
    output      logic               done,
    output      rsp_t               rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output      logic [PDATA_W-1:0] prdata,
    output      logic               pready
);

    logic [CNT_W-1:0] max_entries_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RST;
        end
        else if (cfg_wr && (paddr[2] == REG_MAX_ENTRIES))
        begin
            max_entries_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MAX_ENTRIES)
        begin
            prdata = PDATA_W'({{PDATA_W{1'b0}}, max_entries_reg});
        end
    end

    gpfl_engine #(
        .POOL_DEPTH (POOL_DEPTH),
        .GROW_STEP  (GROW_STEP)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req         (req),
        .max_entries (max_entries_reg),
        .busy        (busy),
        .done        (done),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire

### test/growing_pool_free_list_allocator_test.sv
module growing_pool_free_list_allocator_test
    import gpfl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL = POOL_DEPTH_DEF;
    localparam int STEP = GROW_STEP_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [PADDR_W-1:0] MAX_ENTRIES_ADDR = PADDR_W'(4 * int'(REG_MAX_ENTRIES));

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    req_t               req = '0;
    logic               busy;
    logic               done;
    rsp_t               rsp;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // allocator image kept by the checker
    logic [CNT_W-1:0] max_cfg = MAX_ENTRIES_RST;
    logic [CNT_W-1:0] high_water = '0;
    logic [CNT_W-1:0] capacity = '0;
    logic [CNT_W-1:0] list_len = '0;
    logic [ID_W-1:0]  list_head = '0;
    logic [ID_W-1:0]  list_tail = '0;
    logic [ID_W-1:0]  next_link [POOL];

    rsp_t            pending_rsp [$];
    logic [ID_W-1:0] issued_ids [$];
    int              mismatch_count = 0;
    int              stall_cycles = 0;
    int              burst_left = 0;
    bit              gaps_on = 1'b1;

    growing_pool_free_list_allocator #(
        .POOL_DEPTH (POOL),
        .GROW_STEP  (STEP)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic rsp_t model_request(input req_t r);
        rsp_t o;
        logic refused;
        int   i;
        o.status = ST_OK;
        o.granted_id = '0;
        refused = 1'b0;
        if (r.action == ACT_ALLOC)
        begin
            if (list_len == 0 && high_water >= capacity)
            begin
                if (capacity >= max_cfg || int'(capacity) >= POOL)
                    refused = 1'b1;
                else if (int'(capacity) + STEP > POOL)
                    capacity = CNT_W'(POOL);
                else
                    capacity = capacity + CNT_W'(STEP);
            end
            if (refused)
                o.status = ST_FULL;
            else if (list_len == 0)
            begin
                o.granted_id = high_water[ID_W-1:0];
                high_water++;
            end
            else
            begin
                o.granted_id = list_head;
                if (list_len > 1)
                    list_head = next_link[list_head];
                list_len--;
            end
            if (o.status == ST_OK)
                issued_ids.push_back(o.granted_id);
        end
        else if (r.release_id >= high_water || list_len >= high_water)
            o.status = ST_BADID;
        else
        begin
            if (list_len == 0)
                list_head = r.release_id;
            else
                next_link[list_tail] = r.release_id;
            list_tail = r.release_id;
            list_len++;
            for (i = 0; i < issued_ids.size(); i++)
            begin
                if (issued_ids[i] == r.release_id)
                begin
                    issued_ids.delete(i);
                    break;
                end
            end
        end
        o.free_count = list_len;
        return o;
    endfunction

    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("result word with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        mismatch_count++;
                    end
                    if (rsp.granted_id !== want.granted_id)
                    begin
                        $error("granted_id: expected %0d, got %0d",
                               want.granted_id, rsp.granted_id);
                        mismatch_count++;
                    end
                    if (rsp.free_count !== want.free_count)
                    begin
                        $error("free_count: expected %0d, got %0d",
                               want.free_count, rsp.free_count);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
                pending_rsp.push_back(model_request(req));
            if (psel && penable && pwrite && pready && paddr == MAX_ENTRIES_ADDR)
                max_cfg = pwdata[CNT_W-1:0];
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || psel)
            stall_cycles = 0;
        else if (++stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic pace_sender();
        int gap;
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                gap = $urandom_range(1, 9);
                start = 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    task automatic send_word(input action_t act, input logic [ID_W-1:0] id);
        req.action = act;
        req.release_id = id;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        pace_sender();
    endtask

    task automatic alloc_word();
        send_word(ACT_ALLOC, ID_W'($urandom));
    endtask

    // mostly ids currently handed out, else a random id, anywhere or up to the high water mark
    task automatic release_random(input int held_pct);
        logic [ID_W-1:0] id;
        if (issued_ids.size() != 0 && $urandom_range(99) < held_pct)
            id = issued_ids[$urandom_range(issued_ids.size() - 1)];
        else if ($urandom_range(1))
            id = ID_W'($urandom);
        else
            id = ID_W'($urandom_range(int'(high_water)));
        send_word(ACT_RELEASE, id);
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_max_entries(input logic [CNT_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = MAX_ENTRIES_ADDR;
        pwdata = PDATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic read_max_entries();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = MAX_ENTRIES_ADDR;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== PDATA_W'(max_cfg))
        begin
            $error("max_entries: expected %0d, got %0d", max_cfg, prdata);
            mismatch_count++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic test_register_access();
        read_max_entries();
        write_max_entries(13'd8191);
        read_max_entries();
        write_max_entries(13'd0);
        read_max_entries();
        write_max_entries(MAX_ENTRIES_RST);
        read_max_entries();
    endtask

    task automatic test_edge_requests();
        gaps_on = 1'b0;
        send_word(ACT_RELEASE, 12'd0);
        send_word(ACT_RELEASE, 12'd4095);
        alloc_word();
        alloc_word();
        send_word(ACT_RELEASE, 12'd1);
        send_word(ACT_RELEASE, 12'd1);
        send_word(ACT_RELEASE, 12'd0);
        alloc_word();
        alloc_word();
        alloc_word();
        send_word(ACT_RELEASE, 12'd3);
        send_word(ACT_RELEASE, 12'd2);
        send_word(ACT_RELEASE, 12'd0);
        alloc_word();
        alloc_word();
        alloc_word();
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_growth_limit();
        // one growth step may carry capacity past the limit
        write_max_entries(13'd65);
        repeat (140) alloc_word();
        drain_results();
        write_max_entries(13'd1);
        repeat (5) release_random(100);
        repeat (8) alloc_word();
        drain_results();
        write_max_entries(13'd0);
        alloc_word();
        alloc_word();
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [CNT_W-1:0] limits [5];
        int               seg;
        int               alloc_pct;
        limits[0] = MAX_ENTRIES_RST;
        limits[1] = 13'd300;
        limits[2] = 13'd8191;
        limits[3] = CNT_W'($urandom_range(1, 4096));
        limits[4] = 13'd128;
        for (seg = 0; seg < 5; seg++)
        begin
            write_max_entries(limits[seg]);
            gaps_on = (seg != 2);
            alloc_pct = $urandom_range(45, 65);
            repeat (400)
            begin
                if ($urandom_range(99) < alloc_pct)
                    alloc_word();
                else
                    release_random(85);
            end
            drain_results();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_fill_pool();
        write_max_entries(13'd8191);
        while (high_water < CNT_W'(POOL))
            alloc_word();
        repeat (3) alloc_word();
        send_word(ACT_RELEASE, 12'd4095);
        send_word(ACT_RELEASE, 12'd2048);
        send_word(ACT_RELEASE, 12'd0);
        send_word(ACT_RELEASE, 12'd4095);
        repeat (60)
        begin
            if ($urandom_range(1))
                alloc_word();
            else
                release_random(80);
        end
        drain_results();
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_register_access();
        test_edge_requests();
        test_growth_limit();
        test_random_traffic();
        test_fill_pool();
        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/gpfl_pkg.sv
rtl/core/gpfl_ram.sv
rtl/core/gpfl_engine.sv
rtl/core/growing_pool_free_list_allocator.sv
test/growing_pool_free_list_allocator_test.sv
